### sv/pjq_pkg.sv
// ----------------------------------------------------------------------------
// pjq_pkg
// Shared types and constants for the policy job queue: job record, result
// record, policy and action codes.
// ----------------------------------------------------------------------------
package pjq_pkg;

  // Default number of queue entries.
  localparam int unsigned QueueDepthDefault = 64;

  // Fixed field widths.
  localparam int unsigned TagW      = 8;
  localparam int unsigned TimeW     = 16;
  localparam int unsigned PrioW     = 8;
  localparam int unsigned JobsW     = 7;
  localparam int unsigned PolicyW   = 2;

  // Selection rules; the unused code behaves as first come first served.
  localparam logic [PolicyW-1:0] POLICY_FCFS = 2'd0;
  localparam logic [PolicyW-1:0] POLICY_SJF  = 2'd1;
  localparam logic [PolicyW-1:0] POLICY_PRIO = 2'd2;

  // Item actions.
  localparam logic ACTION_SUBMIT   = 1'b0;
  localparam logic ACTION_DISPATCH = 1'b1;

  // One stored job.
  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [TimeW-1:0] run_time;
    logic [PrioW-1:0] prio;
  } job_t;

  // One result item.
  typedef struct packed {
    logic             submit_accepted;
    logic             queue_full;
    logic             dispatch_valid;
    job_t             job;
    logic [JobsW-1:0] jobs_waiting;
  } result_t;

  // Sequencer to output stage.
  typedef struct packed {
    logic    valid;
    result_t res;
  } res_xfer_t;

endpackage

### sv/policy_job_queue.sv
// ----------------------------------------------------------------------------
// policy_job_queue
// Bounded job queue with first come first served, shortest job and priority
// dispatch rules; ties go to the oldest job.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake               Payload
//   input    in         in_valid_i/in_stall_o   action, job_tag, job_time, job_priority
//   output   out        out_valid_o/out_stall_i submit_accepted .. jobs_waiting
//   config   in         cfg_we_i                cfg_wdata_i (policy)
//
// A submit appends the job unless the queue is full. A dispatch scans every
// queued job, then moves each entry behind the removed job down one place;
// the single read port of the job store serialises these reads.
// Reset empties the queue and selects first come first served at once.
// A stalled result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module policy_job_queue #(
  parameter int unsigned QUEUE_DEPTH = pjq_pkg::QueueDepthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pjq_pkg::PolicyW-1:0]     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            action_i,
  input  logic [pjq_pkg::TagW-1:0]        job_tag_i,
  input  logic [pjq_pkg::TimeW-1:0]       job_time_i,
  input  logic [pjq_pkg::PrioW-1:0]       job_priority_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            submit_accepted_o,
  output logic                            queue_full_o,
  output logic                            dispatch_valid_o,
  output logic [pjq_pkg::TagW-1:0]        out_tag_o,
  output logic [pjq_pkg::TimeW-1:0]       out_time_o,
  output logic [pjq_pkg::PrioW-1:0]       out_priority_o,
  output logic [pjq_pkg::JobsW-1:0]       jobs_waiting_o
);

  localparam int unsigned AddrW = $clog2(QUEUE_DEPTH);

  logic [pjq_pkg::PolicyW-1:0] policy_q;
  pjq_pkg::job_t               job_in;
  pjq_pkg::res_xfer_t          xfer;
  logic                        res_take;
  logic                        out_valid_q;
  pjq_pkg::result_t            out_q;
  logic                        mem_we;
  logic [AddrW-1:0]            mem_waddr;
  pjq_pkg::job_t               mem_wdata;
  logic                        mem_re;
  logic [AddrW-1:0]            mem_raddr;
  pjq_pkg::job_t               mem_rdata;

  // Policy register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= pjq_pkg::POLICY_FCFS;
    end else if (cfg_we_i) begin
      policy_q <= cfg_wdata_i;
    end
  end

  assign job_in.tag      = job_tag_i;
  assign job_in.run_time = job_time_i;
  assign job_in.prio     = job_priority_i;

  pjq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .job_i       (job_in),
    .policy_i    (policy_q),
    .xfer_o      (xfer),
    .res_take_i  (res_take),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  pjq_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: loads a finished result whenever its slot is free.
  assign res_take = xfer.valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= xfer.res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign submit_accepted_o = out_q.submit_accepted;
  assign queue_full_o      = out_q.queue_full;
  assign dispatch_valid_o  = out_q.dispatch_valid;
  assign out_tag_o         = out_q.job.tag;
  assign out_time_o        = out_q.job.run_time;
  assign out_priority_o    = out_q.job.prio;
  assign jobs_waiting_o    = out_q.jobs_waiting;

endmodule

### sv/pjq_mem.sv
// ----------------------------------------------------------------------------
// pjq_mem
// Job store: one write port and one read port with a registered read.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module pjq_mem #(
  parameter int unsigned QUEUE_DEPTH = pjq_pkg::QueueDepthDefault,
  localparam int unsigned AddrW      = $clog2(QUEUE_DEPTH)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  pjq_pkg::job_t       wdata_i,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_i,
  output pjq_pkg::job_t       rdata_o
);

  pjq_pkg::job_t mem_q [QUEUE_DEPTH];
  pjq_pkg::job_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the read data is registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/pjq_ctrl.sv
// ----------------------------------------------------------------------------
// pjq_ctrl
// Item sequencer: appends submitted jobs, and for a dispatch scans the store
// for the selected job, then moves later entries down one place.
// ----------------------------------------------------------------------------
module pjq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = pjq_pkg::QueueDepthDefault,
  localparam int unsigned AddrW      = $clog2(QUEUE_DEPTH),
  localparam int unsigned CountW     = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  pjq_pkg::job_t                  job_i,
  input  logic [pjq_pkg::PolicyW-1:0]    policy_i,
  output pjq_pkg::res_xfer_t             xfer_o,
  input  logic                           res_take_i,
  output logic                           mem_we_o,
  output logic [AddrW-1:0]               mem_waddr_o,
  output pjq_pkg::job_t                  mem_wdata_o,
  output logic                           mem_re_o,
  output logic [AddrW-1:0]               mem_raddr_o,
  input  pjq_pkg::job_t                  mem_rdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [CountW-1:0] occ_q, occ_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [AddrW-1:0]  bidx_q, bidx_d;
  pjq_pkg::job_t     best_q, best_d;
  pjq_pkg::result_t  res_q, res_d;
  logic [AddrW-1:0]  occ_m1;
  logic              take;

  // Strictly better candidate under the current rule; ties keep the older job.
  function automatic logic better(input pjq_pkg::job_t cand, input pjq_pkg::job_t cur,
                                  input logic [pjq_pkg::PolicyW-1:0] pol);
    logic r;
    r = 1'b0;
    case (pol)
      pjq_pkg::POLICY_SJF:  r = cand.run_time < cur.run_time;
      pjq_pkg::POLICY_PRIO: r = cand.prio < cur.prio;
      default:              r = 1'b0;
    endcase
    return r;
  endfunction

  assign occ_m1 = AddrW'(occ_q - 1'b1);
  assign take   = (idx_q == '0) || better(mem_rdata_i, best_q, policy_i);

  // Next-state and memory access logic.
  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    idx_d       = idx_q;
    bidx_d      = bidx_q;
    best_d      = best_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d = '0;
          if (action_i == pjq_pkg::ACTION_SUBMIT) begin
            if (occ_q != CountW'(QUEUE_DEPTH)) begin
              mem_we_o              = 1'b1;
              mem_waddr_o           = occ_q[AddrW-1:0];
              mem_wdata_o           = job_i;
              occ_d                 = CountW'(occ_q + 1'b1);
              res_d.submit_accepted = 1'b1;
            end else begin
              res_d.queue_full = 1'b1;
            end
            res_d.jobs_waiting = pjq_pkg::JobsW'(occ_d);
            state_d            = S_DONE;
          end else if (occ_q == '0) begin
            state_d = S_DONE;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = '0;
            idx_d       = '0;
            state_d     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Data for entry idx_q is on the read port this cycle.
        if (take) begin
          best_d = mem_rdata_i;
          bidx_d = idx_q;
        end
        mem_re_o = 1'b1;
        if (idx_q == occ_m1) begin
          mem_raddr_o = AddrW'(bidx_d + 1'b1);
          idx_d       = bidx_d;
          state_d     = S_SHIFT;
        end else begin
          mem_raddr_o = AddrW'(idx_q + 1'b1);
          idx_d       = AddrW'(idx_q + 1'b1);
        end
      end
      S_SHIFT: begin
        // Entry idx_q + 1 is on the read port; it moves into entry idx_q.
        if (idx_q == occ_m1) begin
          occ_d                = CountW'(occ_q - 1'b1);
          res_d                = '0;
          res_d.dispatch_valid = 1'b1;
          res_d.job            = best_q;
          res_d.jobs_waiting   = pjq_pkg::JobsW'(occ_d);
          state_d              = S_DONE;
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = idx_q;
          mem_wdata_o = mem_rdata_i;
          mem_re_o    = 1'b1;
          mem_raddr_o = AddrW'(idx_q + 2'd2);
          idx_d       = AddrW'(idx_q + 1'b1);
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    bidx_q <= bidx_d;
    best_q <= best_d;
    res_q  <= res_d;
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign xfer_o.valid = (state_q == S_DONE);
  assign xfer_o.res   = res_q;

endmodule

### sv/pjq_checker.sv
// ----------------------------------------------------------------------------
// pjq_checker
// Port-level checks for the policy job queue, attached by bind.
// ----------------------------------------------------------------------------
module pjq_checker #(
  parameter int unsigned QUEUE_DEPTH = pjq_pkg::QueueDepthDefault
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        submit_accepted_o,
  input logic                        queue_full_o,
  input logic                        dispatch_valid_o,
  input logic [pjq_pkg::TagW-1:0]    out_tag_o,
  input logic [pjq_pkg::TimeW-1:0]   out_time_o,
  input logic [pjq_pkg::PrioW-1:0]   out_priority_o,
  input logic [pjq_pkg::JobsW-1:0]   jobs_waiting_o
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_tag_o)
      && $stable(out_time_o) && $stable(jobs_waiting_o))
    else $error("stalled result changed");

  // An item reports at most one outcome.
  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({submit_accepted_o, queue_full_o, dispatch_valid_o}) <= 1)
    else $error("more than one outcome flag set");

  // Without a dispatched job the job fields read zero.
  a_zero_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !dispatch_valid_o |->
      out_tag_o == '0 && out_time_o == '0 && out_priority_o == '0)
    else $error("job fields set without a dispatch");

  // A refused submit leaves the queue at its full depth.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && queue_full_o |-> jobs_waiting_o == pjq_pkg::JobsW'(QUEUE_DEPTH))
    else $error("queue full reported below full depth");

endmodule

bind policy_job_queue pjq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_pjq_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .submit_accepted_o (submit_accepted_o),
  .queue_full_o      (queue_full_o),
  .dispatch_valid_o  (dispatch_valid_o),
  .out_tag_o         (out_tag_o),
  .out_time_o        (out_time_o),
  .out_priority_o    (out_priority_o),
  .jobs_waiting_o    (jobs_waiting_o)
);

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the policy job queue. A short table of directed
// items opens the run, then a long stretch of random submits and dispatches
// under every policy code. A held-off receiver backs the queue up, and the
// queue is filled until submits are refused. Every result item is compared
// field by field against the bench's queue model or a typed row's want.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned   QueueDepth   = pjq_pkg::QueueDepthDefault;
  localparam int unsigned   MaxWait      = 12;
  localparam int unsigned   DrainCycles  = 2 * QueueDepth + 20;
  localparam int unsigned   HoldOffLen   = 500;
  localparam int unsigned   RandPhases   = 14;
  localparam int unsigned   PhaseItems   = 125;
  localparam longint        CycleLimit   = 1200000;
  // Code 3 is not a rule of its own; the block treats it as first come first served.
  localparam logic [pjq_pkg::PolicyW-1:0] POLICY_SPARE = 2'd3;
  localparam pjq_pkg::result_t EMPTY_DISPATCH = '0;

  // One row of the directed table: either a policy write or a job item.
  typedef struct {
    logic                         is_cfg;
    logic [pjq_pkg::PolicyW-1:0]  policy;
    logic                         act;
    pjq_pkg::job_t                job;
    logic                         typed;
    pjq_pkg::result_t             want;
  } stim_row_t;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  // Block ports.
  logic                        cfg_we = 1'b0;
  logic [pjq_pkg::PolicyW-1:0] cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        action = pjq_pkg::ACTION_SUBMIT;
  logic [pjq_pkg::TagW-1:0]    job_tag = '0;
  logic [pjq_pkg::TimeW-1:0]   job_time = '0;
  logic [pjq_pkg::PrioW-1:0]   job_priority = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        submit_accepted;
  logic                        queue_full;
  logic                        dispatch_valid;
  logic [pjq_pkg::TagW-1:0]    out_tag;
  logic [pjq_pkg::TimeW-1:0]   out_time;
  logic [pjq_pkg::PrioW-1:0]   out_priority;
  logic [pjq_pkg::JobsW-1:0]   jobs_waiting;

  policy_job_queue #(
    .QUEUE_DEPTH(QueueDepth)
  ) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .action_i         (action),
    .job_tag_i        (job_tag),
    .job_time_i       (job_time),
    .job_priority_i   (job_priority),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .submit_accepted_o(submit_accepted),
    .queue_full_o     (queue_full),
    .dispatch_valid_o (dispatch_valid),
    .out_tag_o        (out_tag),
    .out_time_o       (out_time),
    .out_priority_o   (out_priority),
    .jobs_waiting_o   (jobs_waiting)
  );

  // Queue model state and bookkeeping.
  pjq_pkg::job_t               queued_jobs[$];
  logic [pjq_pkg::PolicyW-1:0] active_policy = pjq_pkg::POLICY_FCFS;
  pjq_pkg::result_t            job_outcomes[$];
  int unsigned                 error_count = 0;
  int unsigned                 items_sent = 0;
  int unsigned                 results_seen = 0;
  int unsigned                 refused_submits = 0;
  int unsigned                 empty_dispatches = 0;
  int unsigned                 hold_request = 0;
  logic                        tx_idle_on = 1'b1;
  logic                        rx_idle_on = 1'b1;
  longint                      cycle_count = 0;
  stim_row_t                   stim_rows[$];

  // Applies one item to the queue model and returns the result it should give.
  function automatic pjq_pkg::result_t apply_job_action(logic act, pjq_pkg::job_t job);
    pjq_pkg::result_t res;
    int unsigned      pick;
    res = '0;
    pick = 0;
    if (act == pjq_pkg::ACTION_SUBMIT) begin
      if (queued_jobs.size() < QueueDepth) begin
        queued_jobs.push_back(job);
        res.submit_accepted = 1'b1;
      end else begin
        res.queue_full = 1'b1;
        refused_submits++;
      end
    end else if (queued_jobs.size() > 0) begin
      // Strict comparison keeps ties on the oldest job.
      for (int i = 1; i < queued_jobs.size(); i++) begin
        if (active_policy == pjq_pkg::POLICY_SJF &&
            queued_jobs[i].run_time < queued_jobs[pick].run_time)
          pick = i;
        if (active_policy == pjq_pkg::POLICY_PRIO &&
            queued_jobs[i].prio < queued_jobs[pick].prio)
          pick = i;
      end
      res.job = queued_jobs[pick];
      res.dispatch_valid = 1'b1;
      queued_jobs.delete(pick);
    end else begin
      empty_dispatches++;
    end
    res.jobs_waiting = pjq_pkg::JobsW'(queued_jobs.size());
    return res;
  endfunction

  // Small values and all-zero/all-one values make ties and extremes common.
  function automatic int unsigned draw_value(int unsigned width);
    int unsigned top;
    top = (1 << width) - 1;
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: return $urandom_range(0, 1) ? top : 0;
      default: return $urandom & top;
    endcase
  endfunction

  function automatic pjq_pkg::job_t random_job();
    pjq_pkg::job_t job;
    job.tag      = pjq_pkg::TagW'($urandom);
    job.run_time = pjq_pkg::TimeW'(draw_value(pjq_pkg::TimeW));
    job.prio     = pjq_pkg::PrioW'(draw_value(pjq_pkg::PrioW));
    return job;
  endfunction

  function automatic stim_row_t item_row(logic act, int unsigned tag, int unsigned cpu,
                                         int unsigned prio);
    stim_row_t row;
    row.is_cfg       = 1'b0;
    row.policy       = pjq_pkg::POLICY_FCFS;
    row.act          = act;
    row.job.tag      = pjq_pkg::TagW'(tag);
    row.job.run_time = pjq_pkg::TimeW'(cpu);
    row.job.prio     = pjq_pkg::PrioW'(prio);
    row.typed        = 1'b0;
    row.want         = '0;
    return row;
  endfunction

  function automatic stim_row_t typed_row(logic act, int unsigned tag, int unsigned cpu,
                                          int unsigned prio, pjq_pkg::result_t want);
    stim_row_t row;
    row = item_row(act, tag, cpu, prio);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [pjq_pkg::PolicyW-1:0] policy);
    stim_row_t row;
    row = item_row(pjq_pkg::ACTION_SUBMIT, 0, 0, 0);
    row.is_cfg = 1'b1;
    row.policy = policy;
    return row;
  endfunction

  // Offers one item, waits for it to be taken and records its result.
  task automatic send_item(logic act, pjq_pkg::job_t job, logic typed,
                           pjq_pkg::result_t want);
    int unsigned      gap;
    pjq_pkg::result_t outcome;
    gap = tx_idle_on ? $urandom_range(0, MaxWait) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    job_tag      <= job.tag;
    job_time     <= job.run_time;
    job_priority <= job.prio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    outcome = apply_job_action(act, job);
    job_outcomes.push_back(typed ? want : outcome);
    items_sent++;
  endtask

  // Policy writes happen only once every outstanding result has come back.
  task automatic write_policy(logic [pjq_pkg::PolicyW-1:0] policy);
    in_valid <= 1'b0;
    while (job_outcomes.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= policy;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_policy = policy;
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Result side: check each taken item and draw the stall before the next one.
  initial begin : result_monitor
    int unsigned      stall_left;
    int unsigned      holdoff_left;
    pjq_pkg::result_t got;
    pjq_pkg::result_t want;
    stall_left   = 0;
    holdoff_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.submit_accepted = submit_accepted;
        got.queue_full      = queue_full;
        got.dispatch_valid  = dispatch_valid;
        got.job.tag         = out_tag;
        got.job.run_time    = out_time;
        got.job.prio        = out_priority;
        got.jobs_waiting    = jobs_waiting;
        results_seen++;
        if (job_outcomes.size() == 0) begin
          error_count++;
          $display("%0t: result item with nothing outstanding, got %h", $time, got);
        end else begin
          want = job_outcomes.pop_front();
          compare_field("submit_accepted", want.submit_accepted, got.submit_accepted);
          compare_field("queue_full", want.queue_full, got.queue_full);
          compare_field("dispatch_valid", want.dispatch_valid, got.dispatch_valid);
          compare_field("out_tag", want.job.tag, got.job.tag);
          compare_field("out_time", want.job.run_time, got.job.run_time);
          compare_field("out_priority", want.job.prio, got.job.prio);
          compare_field("jobs_waiting", want.jobs_waiting, got.jobs_waiting);
        end
        stall_left = rx_idle_on ? $urandom_range(0, MaxWait) : 0;
      end
      // A long hold-off lets the block back up into its input.
      if (hold_request != 0) begin
        holdoff_left = hold_request;
        hold_request = 0;
      end
      out_stall <= (stall_left != 0) || (holdoff_left != 0);
      if (stall_left != 0) stall_left--;
      if (holdoff_left != 0) holdoff_left--;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Stimulus.
  initial begin : stimulus
    int unsigned submit_pct;
    logic        act;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: reset state and field extremes under the reset policy.
    stim_rows.push_back(typed_row(pjq_pkg::ACTION_DISPATCH, 0, 0, 0, EMPTY_DISPATCH));
    stim_rows.push_back(typed_row(pjq_pkg::ACTION_SUBMIT, 0, 0, 0,
                                  {1'b1, 1'b0, 1'b0, 8'd0, 16'd0, 8'd0, 7'd1}));
    stim_rows.push_back(typed_row(pjq_pkg::ACTION_SUBMIT, 255, 65535, 255,
                                  {1'b1, 1'b0, 1'b0, 8'd0, 16'd0, 8'd0, 7'd2}));
    stim_rows.push_back(item_row(pjq_pkg::ACTION_SUBMIT, 8'h5A, 16'h1234, 7));
    stim_rows.push_back(typed_row(pjq_pkg::ACTION_DISPATCH, 0, 0, 0,
                                  {1'b0, 1'b0, 1'b1, 8'd0, 16'd0, 8'd0, 7'd2}));
    stim_rows.push_back(typed_row(pjq_pkg::ACTION_DISPATCH, 0, 0, 0,
                                  {1'b0, 1'b0, 1'b1, 8'hFF, 16'hFFFF, 8'hFF, 7'd1}));
    stim_rows.push_back(item_row(pjq_pkg::ACTION_DISPATCH, 0, 0, 0));
    stim_rows.push_back(typed_row(pjq_pkg::ACTION_DISPATCH, 0, 0, 0, EMPTY_DISPATCH));
    // Shortest job with a tie on time.
    stim_rows.push_back(cfg_row(pjq_pkg::POLICY_SJF));
    stim_rows.push_back(item_row(pjq_pkg::ACTION_SUBMIT, 1, 500, 9));
    stim_rows.push_back(item_row(pjq_pkg::ACTION_SUBMIT, 2, 100, 3));
    stim_rows.push_back(item_row(pjq_pkg::ACTION_SUBMIT, 3, 100, 1));
    stim_rows.push_back(item_row(pjq_pkg::ACTION_SUBMIT, 4, 65535, 0));
    stim_rows.push_back(item_row(pjq_pkg::ACTION_DISPATCH, 0, 0, 0));
    stim_rows.push_back(item_row(pjq_pkg::ACTION_DISPATCH, 0, 0, 0));
    // Priority with a tie on the smallest value.
    stim_rows.push_back(cfg_row(pjq_pkg::POLICY_PRIO));
    stim_rows.push_back(item_row(pjq_pkg::ACTION_SUBMIT, 5, 7, 255));
    stim_rows.push_back(item_row(pjq_pkg::ACTION_SUBMIT, 6, 8, 0));
    stim_rows.push_back(item_row(pjq_pkg::ACTION_DISPATCH, 0, 0, 0));
    stim_rows.push_back(item_row(pjq_pkg::ACTION_DISPATCH, 0, 0, 0));
    stim_rows.push_back(item_row(pjq_pkg::ACTION_DISPATCH, 0, 0, 0));
    // The spare policy code serves the oldest job.
    stim_rows.push_back(cfg_row(POLICY_SPARE));
    stim_rows.push_back(item_row(pjq_pkg::ACTION_SUBMIT, 7, 1, 1));
    stim_rows.push_back(item_row(pjq_pkg::ACTION_DISPATCH, 0, 0, 0));
    stim_rows.push_back(item_row(pjq_pkg::ACTION_DISPATCH, 0, 0, 0));
    stim_rows.push_back(typed_row(pjq_pkg::ACTION_DISPATCH, 0, 0, 0, EMPTY_DISPATCH));

    foreach (stim_rows[r]) begin
      if (stim_rows[r].is_cfg)
        write_policy(stim_rows[r].policy);
      else
        send_item(stim_rows[r].act, stim_rows[r].job, stim_rows[r].typed, stim_rows[r].want);
    end

    // Back-pressure: the receiver holds off while submits pile up past full.
    write_policy(pjq_pkg::POLICY_PRIO);
    tx_idle_on = 1'b0;
    hold_request = HoldOffLen;
    repeat (QueueDepth + 6) send_item(pjq_pkg::ACTION_SUBMIT, random_job(), 1'b0, '0);
    repeat (QueueDepth + 2) send_item(pjq_pkg::ACTION_DISPATCH, random_job(), 1'b0, '0);

    // Random phases: every policy code, with the submit share steering the fill level.
    for (int phase = 0; phase < RandPhases; phase++) begin
      write_policy(pjq_pkg::PolicyW'(phase % 4));
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      case (phase % 3)
        0: submit_pct = 80;
        1: submit_pct = 50;
        default: submit_pct = 30;
      endcase
      repeat (PhaseItems) begin
        act = ($urandom_range(0, 99) < submit_pct) ? pjq_pkg::ACTION_SUBMIT
                                                    : pjq_pkg::ACTION_DISPATCH;
        send_item(act, random_job(), 1'b0, '0);
      end
    end

    // Drain and let any stray result show up.
    in_valid <= 1'b0;
    while (job_outcomes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Run covered %0d items and %0d results over %0d cycles, all four policy codes.",
             items_sent, results_seen, cycle_count);
    $display("Refused submits on a full queue: %0d, dispatches from an empty queue: %0d.",
             refused_submits, empty_dispatches);
    if (error_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
